### rtl/lltf_pkg.sv
// Package: widths, codes and defaults for the linked list table with free list.
package lltf_pkg;
  localparam int SLOTS_DEF = 64;
  localparam int MAX_CAP   = 64;
  localparam int CAP_W     = 7;
  localparam int KEY_W     = 31;
  localparam int PAY_W     = 64;
  localparam int CMD_W     = 2;
  localparam int ST_W      = 2;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SORTED = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd3;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_DUP    = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd3;

  localparam logic [2:0] REG_CAPACITY = 3'd0;
endpackage

### rtl/lltf_if.sv
// Interfaces: command item channel and result item channel.
interface lltf_in_if import lltf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [KEY_W-1:0] key;
  logic [PAY_W-1:0] payload;
  modport source (output valid, command, key, payload, input ready);
  modport sink (input valid, command, key, payload, output ready);
endinterface

interface lltf_out_if import lltf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [CAP_W-1:0] slot;
  logic [PAY_W-1:0] found_payload;
  logic [CAP_W-1:0] record_count;
  modport source (output valid, status, slot, found_payload, record_count, input ready);
  modport sink (input valid, status, slot, found_payload, record_count, output ready);
endinterface

### rtl/lltf_ram.sv
// Generic single write port RAM with registered read.
module lltf_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/linked_list_table_with_free_list_top.sv
// Top level: keyed record table, doubly linked list over a slot pool plus free chain.
// Per item: list hops to the hit or the list end, then decision and update, then the
// output state, which holds until the result is taken, then the idle state.
// One item at a time: the list walk over the link memories sets the rate.
// Reset: synchronous; capacity returns to min(SLOTS, 64) and a clearing pass over all
// SLOTS+1 entries rebuilds the link memories; a capacity write starts the same pass.
module linked_list_table_with_free_list_top import lltf_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lltf_in_if.sink     in_ch,
  lltf_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int SW = $clog2(SLOTS + 1);
  localparam int D  = SLOTS + 1;
  localparam int CW = (SW > CAP_W) ? SW : CAP_W;
  localparam logic [SW-1:0] NUL = '0;
  localparam logic [SW-1:0] LAST = SW'(SLOTS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;
  localparam logic [2:0] S_A1   = 3'd5;
  localparam logic [2:0] S_A2   = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]       state;
  logic [CAP_W-1:0] cap;
  logic [SW-1:0]    idx, cur, hit, at, sl, aux_a, aux_b;
  logic [SW-1:0]    head, tail, free_head;
  logic [CAP_W-1:0] live_count;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] key;
  logic [PAY_W-1:0] pay;
  logic [ST_W-1:0]  o_status;
  logic [SW-1:0]    o_slot;
  logic [PAY_W-1:0] o_found;

  logic             cfg_wr;
  logic [CAP_W-1:0] cap_in, cap_clamped;
  logic             is_ins;

  logic             n_we, p_we, k_we;
  logic [SW-1:0]    n_wa, p_wa, n_wd, p_wd, n_ra, p_ra;
  logic [SW-1:0]    n_rd, p_rd;
  logic [KEY_W-1:0] k_rd;
  logic [PAY_W-1:0] pay_rd;

  assign pready = 1'b1;
  assign prdata = 32'(cap);
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY[2]);
  assign cap_in = pwdata[CAP_W-1:0];
  assign is_ins = (cmd == CMD_APPEND) || (cmd == CMD_SORTED);

  always_comb begin
    cap_clamped = cap_in;
    if (cap_clamped == '0) cap_clamped = CAP_W'(1);
    if (cap_clamped > CAP_W'(MAX_CAP)) cap_clamped = CAP_W'(MAX_CAP);
    if (CW'(cap_clamped) > CW'(SLOTS)) cap_clamped = CAP_W'(SLOTS);
  end

  assign in_ch.ready = (state == S_IDLE) && !cfg_wr;
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.status = o_status;
  assign out_ch.slot = CAP_W'(o_slot);
  assign out_ch.found_payload = o_found;
  assign out_ch.record_count = live_count;

  assign k_we = (state == S_A1) && is_ins;
  assign n_ra = (state == S_DEC) ? (is_ins ? free_head : hit) : cur;
  assign p_ra = is_ins ? at : hit;

  always_comb begin
    n_we = 1'b0; n_wa = idx; n_wd = NUL;
    p_we = 1'b0; p_wa = idx; p_wd = NUL;
    case (state)
      S_CLR: begin
        n_we = 1'b1;
        p_we = 1'b1;
        if (idx != NUL && CW'(idx) < CW'(cap)) n_wd = idx + SW'(1);
      end
      S_A1: begin
        n_we = (cmd != CMD_SEARCH);
        p_we = (cmd != CMD_SEARCH);
        if (is_ins) begin
          n_wa = sl; n_wd = at;
          p_wa = sl; p_wd = (at != NUL) ? p_rd : tail;
        end else begin
          n_wa = hit; n_wd = free_head;
          p_wa = hit; p_wd = NUL;
        end
      end
      S_A2: begin
        if (is_ins) begin
          n_we = (aux_a != NUL); n_wa = aux_a; n_wd = sl;
          p_we = (at != NUL); p_wa = at; p_wd = sl;
        end else begin
          n_we = (aux_a != NUL); n_wa = aux_a; n_wd = aux_b;
          p_we = (aux_b != NUL); p_wa = aux_b; p_wd = aux_a;
        end
      end
      default: ;
    endcase
  end

  lltf_ram #(.W(SW), .D(D)) u_next (
    .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));
  lltf_ram #(.W(SW), .D(D)) u_prev (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  lltf_ram #(.W(KEY_W), .D(D)) u_key (
    .clk(clk), .we(k_we), .waddr(sl), .wdata(key), .raddr(cur), .rdata(k_rd));
  lltf_ram #(.W(PAY_W), .D(D)) u_pay (
    .clk(clk), .we(k_we), .waddr(sl), .wdata(pay), .raddr(hit), .rdata(pay_rd));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cap <= CAP_W'((SLOTS < MAX_CAP) ? SLOTS : MAX_CAP);
      idx <= NUL;
      head <= NUL; tail <= NUL; free_head <= SW'(1); live_count <= '0;
    end else if (cfg_wr) begin
      state <= S_CLR;
      cap <= cap_clamped;
      idx <= NUL;
      head <= NUL; tail <= NUL; free_head <= SW'(1); live_count <= '0;
    end else begin
      case (state)
        S_CLR: begin
          idx <= idx + SW'(1);
          if (idx == LAST) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd <= in_ch.command; key <= in_ch.key; pay <= in_ch.payload;
            cur <= head; hit <= NUL; at <= NUL;
            state <= (head == NUL) ? S_DEC : S_RD;
          end
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (k_rd == key) begin
            hit <= cur;
            state <= S_DEC;
          end else begin
            if (cmd == CMD_SORTED && at == NUL && k_rd > key) at <= cur;
            cur <= n_rd;
            state <= (n_rd == NUL) ? S_DEC : S_RD;
          end
        end
        S_DEC: begin
          o_status <= ST_OK; o_slot <= NUL; o_found <= '0;
          if (is_ins) begin
            if (hit != NUL) begin
              o_status <= ST_DUP; state <= S_OUT;
            end else if (free_head == NUL) begin
              o_status <= ST_FULL; state <= S_OUT;
            end else begin
              sl <= free_head; o_slot <= free_head; state <= S_A1;
            end
          end else if (hit == NUL) begin
            o_status <= ST_ABSENT; state <= S_OUT;
          end else begin
            o_slot <= hit; state <= S_A1;
          end
        end
        S_A1: begin
          if (is_ins) begin
            free_head <= n_rd;
            aux_a <= (at != NUL) ? p_rd : tail;
            state <= S_A2;
          end else if (cmd == CMD_REMOVE) begin
            aux_a <= p_rd; aux_b <= n_rd;
            free_head <= hit;
            live_count <= live_count - CAP_W'(1);
            state <= S_A2;
          end else begin
            o_found <= pay_rd;
            state <= S_OUT;
          end
        end
        S_A2: begin
          if (is_ins) begin
            if (aux_a == NUL) head <= sl;
            if (at == NUL) tail <= sl;
            live_count <= live_count + CAP_W'(1);
          end else if (live_count == '0) begin
            head <= NUL; tail <= NUL;
          end else begin
            if (aux_a == NUL) head <= aux_b;
            if (aux_b == NUL) tail <= aux_a;
          end
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst) live_count <= cap)
    else $error("record count above capacity");
  a_fail_no_slot: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status != ST_OK) |-> out_ch.slot == '0)
    else $error("failed command reports a slot");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && !cfg_wr) |=> state == S_IDLE)
    else $error("no return to idle after result item");
  a_clr_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !in_ch.ready)
    else $error("ready during clearing pass");
endmodule
